/* rtl/core/assert_macros.svh */
// assertion helpers for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational invariant checked at every rising clock edge
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lsid_pkg.sv */
package lsid_pkg;

    localparam int CODE_W   = 5;
    localparam int VALUE_W  = 16;
    localparam int SCALED_W = 39;
    localparam int MULT_W   = 11;
    localparam int PROD_W   = VALUE_W + MULT_W;
    localparam int DEN_W    = 15;

    localparam logic [SCALED_W-1:0] SCALED_ALL = '1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
    } t_in_req;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [VALUE_W-1:0]  value_out;
        logic [SCALED_W-1:0] scaled;
        logic                last;
    } t_out_req;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR,
        PH_CMD,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_RSTART  = 3'd1;
    localparam logic [2:0] KIND_STOP    = 3'd2;
    localparam logic [2:0] KIND_ADDR_WR = 3'd3;
    localparam logic [2:0] KIND_ADDR_RD = 3'd4;
    localparam logic [2:0] KIND_DATA_WR = 3'd5;
    localparam logic [2:0] KIND_DATA_RD = 3'd6;

    localparam logic [CODE_W-1:0] CODE_ADDR_LOW   = 5'd0;
    localparam logic [CODE_W-1:0] CODE_ADDR_HIGH  = 5'd1;
    localparam logic [CODE_W-1:0] CODE_POWER_DOWN = 5'd2;
    localparam logic [CODE_W-1:0] CODE_POWER_UP   = 5'd3;
    localparam logic [CODE_W-1:0] CODE_RESET      = 5'd4;
    localparam logic [CODE_W-1:0] CODE_MT_HIGH    = 5'd5;
    localparam logic [CODE_W-1:0] CODE_MT_LOW     = 5'd6;
    localparam logic [CODE_W-1:0] CODE_MODE_CH    = 5'd7;
    localparam logic [CODE_W-1:0] CODE_MODE_CH2   = 5'd8;
    localparam logic [CODE_W-1:0] CODE_MODE_CL    = 5'd9;
    localparam logic [CODE_W-1:0] CODE_MODE_OH    = 5'd10;
    localparam logic [CODE_W-1:0] CODE_MODE_OH2   = 5'd11;
    localparam logic [CODE_W-1:0] CODE_MODE_OL    = 5'd12;
    localparam logic [CODE_W-1:0] CODE_DATA       = 5'd13;
    localparam logic [CODE_W-1:0] CODE_RESERVED   = 5'd14;
    localparam logic [CODE_W-1:0] CODE_CHECK      = 5'd15;
    localparam logic [CODE_W-1:0] CODE_WRITE      = 5'd16;
    localparam logic [CODE_W-1:0] CODE_READ       = 5'd17;
    localparam logic [CODE_W-1:0] CODE_SENS       = 5'd18;
    localparam logic [CODE_W-1:0] CODE_LIGHT      = 5'd19;
    localparam logic [CODE_W-1:0] CODE_MTREG      = 5'd20;
    localparam logic [CODE_W-1:0] CODE_BAD_ADDR   = 5'd21;

    localparam logic [7:0] ADDR_LOW  = 8'h23;
    localparam logic [7:0] ADDR_HIGH = 8'h5C;

    localparam logic [7:0] CMD_POWER_DOWN = 8'h00;
    localparam logic [7:0] CMD_POWER_UP   = 8'h01;
    localparam logic [7:0] CMD_RESET      = 8'h07;
    localparam logic [7:0] CMD_MODE_CH    = 8'h10;
    localparam logic [7:0] CMD_MODE_CH2   = 8'h11;
    localparam logic [7:0] CMD_MODE_CL    = 8'h13;
    localparam logic [7:0] CMD_MODE_OH    = 8'h20;
    localparam logic [7:0] CMD_MODE_OH2   = 8'h21;
    localparam logic [7:0] CMD_MODE_OL    = 8'h23;
    localparam logic [7:0] CMD_MT_HIGH    = 8'h40;
    localparam logic [7:0] CMD_MT_LOW     = 8'h60;
    localparam logic [7:0] CMD_CLASS_MASK = 8'hE0;
    localparam logic [7:0] MODE_FIRST     = 8'h10;
    localparam logic [7:0] MODE_LAST      = 8'h23;

    localparam logic [7:0] MODE_RESET  = 8'h10;
    localparam logic [7:0] MTREG_RESET = 8'd69;
    localparam logic [6:0] SLAVE_RESET = 7'h23;

    localparam logic [2:0] BYTE_PAIR = 3'd2;
    localparam logic [2:0] BYTE_MAX  = 3'd4;

    localparam logic [1:0] ACC_MAXIMAL = 2'd1;
    localparam logic [1:0] ACC_MINIMAL = 2'd2;

    // 69 * numerator of the accuracy ratio
    localparam logic [MULT_W-1:0] GAIN_TYP  = 11'd345;
    localparam logic [MULT_W-1:0] GAIN_WIDE = 11'd1725;

    localparam logic [5:0] DIV_TYP = 6'd6;
    localparam logic [5:0] DIV_MAX = 6'd36;
    localparam logic [5:0] DIV_MIN = 6'd24;

endpackage

/* rtl/core/light_sensor_i2c_decoder_unit.sv */
// Ambient light sensor transaction decoder.
// Input channel (i_in_valid / o_in_stall / i_in_data): one decoded bus event per
// request; kind and byte value. Output channel (o_out_valid / i_out_stall /
// o_out_data): zero to two result requests per event, the final one flagged by last.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): accuracy choice, always
// ready, to be written only while the block is idle; the block does not enforce this.
// Each result request is registered in a pending slot and then moved into the
// output register. A sensitivity or lux value is scaled first: a restoring divider
// retires one quotient bit per cycle across the whole numerator, and the pending
// results move on only once the divider has returned to idle.
// No new event is accepted while results are pending or being scaled.
// The next event is accepted as soon as the last result sits in the output
// register, even while the receiver stalls it; further events wait on o_in_stall.
// Reset (synchronous, active low) returns the transaction to idle, the sensor
// registers to their power-on values and drops any pending results.
// A stalled output request holds its value until it is taken.
`include "assert_macros.svh"

module light_sensor_i2c_decoder_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lsid_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lsid_pkg::t_out_req o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_data
);

    localparam int NUM_W  = lsid_pkg::PROD_W + FRACTION_BITS;
    localparam int QW     = (NUM_W > lsid_pkg::SCALED_W) ? NUM_W : lsid_pkg::SCALED_W;
    localparam int STEP_W = $clog2(NUM_W);

    lsid_pkg::t_phase   r_phase, n_phase;
    lsid_pkg::t_state   r_state, n_state;
    logic [6:0]         r_slave, n_slave;
    logic               r_wd, n_wd;
    logic [7:0]         r_last_cmd, n_last_cmd;
    logic [7:0]         r_mode, n_mode;
    logic [7:0]         r_tr, n_tr;
    logic [7:0]         r_first, n_first;
    logic [7:0]         r_second, n_second;
    logic [2:0]         r_bc, n_bc;
    logic [1:0]         r_acc;

    lsid_pkg::t_out_req r_e0, n_e0;
    lsid_pkg::t_out_req r_e1, n_e1;
    logic [1:0]         r_cnt, n_cnt;
    logic               r_sc_hi, n_sc_hi;
    logic [15:0]        r_raw, n_raw;
    lsid_pkg::t_out_req r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [NUM_W-1:0]          r_num, n_num;
    logic [lsid_pkg::DEN_W-1:0] r_rem, n_rem;
    logic [lsid_pkg::DEN_W-1:0] r_den, n_den;
    logic [STEP_W-1:0]         r_step, n_step;

    logic [lsid_pkg::CODE_W-1:0] cmd_code;

    function automatic lsid_pkg::t_out_req mk_res(
        input logic [lsid_pkg::CODE_W-1:0]  code,
        input logic [lsid_pkg::VALUE_W-1:0] value,
        input logic                         last
    );
        lsid_pkg::t_out_req res;
        res.code      = code;
        res.value_out = value;
        res.scaled    = '0;
        res.last      = last;
        return res;
    endfunction

    assign o_in_stall  = (r_state != lsid_pkg::ST_IDLE) || (r_cnt != 2'd0);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (i_in_data.value)
            lsid_pkg::CMD_POWER_DOWN: cmd_code = lsid_pkg::CODE_POWER_DOWN;
            lsid_pkg::CMD_POWER_UP:   cmd_code = lsid_pkg::CODE_POWER_UP;
            lsid_pkg::CMD_RESET:      cmd_code = lsid_pkg::CODE_RESET;
            lsid_pkg::CMD_MODE_CH:    cmd_code = lsid_pkg::CODE_MODE_CH;
            lsid_pkg::CMD_MODE_CH2:   cmd_code = lsid_pkg::CODE_MODE_CH2;
            lsid_pkg::CMD_MODE_CL:    cmd_code = lsid_pkg::CODE_MODE_CL;
            lsid_pkg::CMD_MODE_OH:    cmd_code = lsid_pkg::CODE_MODE_OH;
            lsid_pkg::CMD_MODE_OH2:   cmd_code = lsid_pkg::CODE_MODE_OH2;
            lsid_pkg::CMD_MODE_OL:    cmd_code = lsid_pkg::CODE_MODE_OL;
            default:                  cmd_code = lsid_pkg::CODE_RESERVED;
        endcase
    end

    always_comb begin
        logic                       in_acc;
        logic                       pop;
        logic                       do_finish;
        logic                       wr;
        logic [7:0]                 v;
        logic [2:0]                 kind;
        logic                       has_mt;
        logic                       has_mode;
        logic [lsid_pkg::PROD_W-1:0] prod;
        logic [lsid_pkg::MULT_W-1:0] gain;
        logic [5:0]                 dsel;
        logic [lsid_pkg::DEN_W-1:0] den;
        logic [lsid_pkg::DEN_W:0]   trial;
        logic                       qb;
        logic [QW-1:0]              q_ext;
        logic [lsid_pkg::SCALED_W-1:0] sc;

        n_phase     = r_phase;
        n_state     = r_state;
        n_slave     = r_slave;
        n_wd        = r_wd;
        n_last_cmd  = r_last_cmd;
        n_mode      = r_mode;
        n_tr        = r_tr;
        n_first     = r_first;
        n_second    = r_second;
        n_bc        = r_bc;
        n_e0        = r_e0;
        n_e1        = r_e1;
        n_cnt       = r_cnt;
        n_sc_hi     = r_sc_hi;
        n_raw       = r_raw;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_num       = r_num;
        n_rem       = r_rem;
        n_den       = r_den;
        n_step      = r_step;

        in_acc    = i_in_valid && !o_in_stall;
        v         = i_in_data.value;
        kind      = i_in_data.kind;
        wr        = (kind == lsid_pkg::KIND_ADDR_WR);
        do_finish = 1'b0;
        has_mt    = (r_last_cmd == lsid_pkg::CMD_MT_HIGH) || (r_last_cmd == lsid_pkg::CMD_MT_LOW);
        has_mode  = (r_mode >= lsid_pkg::MODE_FIRST) && (r_mode <= lsid_pkg::MODE_LAST);
        prod      = '0;
        gain      = lsid_pkg::GAIN_TYP;
        dsel      = lsid_pkg::DIV_TYP;
        den       = '0;
        trial     = '0;
        qb        = 1'b0;
        q_ext     = '0;
        sc        = '0;

        // output register
        pop = (r_state == lsid_pkg::ST_IDLE) && (r_cnt != 2'd0)
              && (!r_out_valid || !i_out_stall);
        if (pop) begin
            n_out       = r_e0;
            n_out_valid = 1'b1;
            n_e0        = r_e1;
            n_cnt       = r_cnt - 2'd1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // scaling sequencer
        case (r_state)
            lsid_pkg::ST_PREP: begin
                if (r_acc == lsid_pkg::ACC_MAXIMAL) begin
                    gain = lsid_pkg::GAIN_WIDE;
                    dsel = lsid_pkg::DIV_MAX;
                end else if (r_acc == lsid_pkg::ACC_MINIMAL) begin
                    gain = lsid_pkg::GAIN_WIDE;
                    dsel = lsid_pkg::DIV_MIN;
                end
                prod = lsid_pkg::PROD_W'(r_raw) * lsid_pkg::PROD_W'(gain);
                den  = lsid_pkg::DEN_W'(dsel) * lsid_pkg::DEN_W'(r_tr);
                if (r_mode == lsid_pkg::CMD_MODE_CH2 || r_mode == lsid_pkg::CMD_MODE_OH2) begin
                    den = den << 1;
                end
                n_num  = NUM_W'(prod) << FRACTION_BITS;
                n_rem  = '0;
                n_den  = den;
                n_step = STEP_W'(NUM_W - 1);
                if (r_tr == 8'd0) begin
                    if (r_sc_hi) begin
                        n_e1.scaled = lsid_pkg::SCALED_ALL;
                    end else begin
                        n_e0.scaled = lsid_pkg::SCALED_ALL;
                    end
                    n_state = lsid_pkg::ST_IDLE;
                end else begin
                    n_state = lsid_pkg::ST_DIV;
                end
            end
            lsid_pkg::ST_DIV: begin
                trial = {r_rem, r_num[NUM_W-1]};
                if (trial >= {1'b0, r_den}) begin
                    qb    = 1'b1;
                    trial = trial - {1'b0, r_den};
                end
                n_rem = trial[lsid_pkg::DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], qb};
                if (r_step == '0) begin
                    n_state = lsid_pkg::ST_FIN;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            lsid_pkg::ST_FIN: begin
                q_ext = QW'(r_num);
                if (q_ext > QW'(lsid_pkg::SCALED_ALL)) begin
                    sc = lsid_pkg::SCALED_ALL;
                end else begin
                    sc = lsid_pkg::SCALED_W'(q_ext);
                end
                if (r_sc_hi) begin
                    n_e1.scaled = sc;
                end else begin
                    n_e0.scaled = sc;
                end
                n_state = lsid_pkg::ST_IDLE;
            end
            default: begin
                n_state = r_state;
            end
        endcase

        // event decode
        if (in_acc) begin
            case (r_phase)
                lsid_pkg::PH_IDLE: begin
                    if (kind == lsid_pkg::KIND_START) begin
                        n_phase = lsid_pkg::PH_ADDR;
                        n_bc    = '0;
                    end
                end
                lsid_pkg::PH_ADDR: begin
                    if (kind == lsid_pkg::KIND_ADDR_WR || kind == lsid_pkg::KIND_ADDR_RD) begin
                        if (v == lsid_pkg::ADDR_LOW || v == lsid_pkg::ADDR_HIGH) begin
                            n_slave = v[6:0];
                            n_wd    = wr;
                            n_e0    = mk_res((v == lsid_pkg::ADDR_LOW) ? lsid_pkg::CODE_ADDR_LOW
                                             : lsid_pkg::CODE_ADDR_HIGH, 16'(v), 1'b0);
                            n_e1    = mk_res(wr ? lsid_pkg::CODE_WRITE : lsid_pkg::CODE_READ,
                                             '0, 1'b1);
                            n_cnt   = 2'd2;
                            n_phase = lsid_pkg::PH_CMD;
                        end else begin
                            n_e0    = mk_res(lsid_pkg::CODE_BAD_ADDR, 16'(r_slave), 1'b1);
                            n_cnt   = 2'd1;
                            n_phase = lsid_pkg::PH_IDLE;
                        end
                    end
                end
                lsid_pkg::PH_CMD: begin
                    if (kind == lsid_pkg::KIND_DATA_WR) begin
                        n_phase    = lsid_pkg::PH_DATA;
                        n_cnt      = 2'd1;
                        n_last_cmd = v;
                        if ((v & lsid_pkg::CMD_CLASS_MASK) == lsid_pkg::CMD_MT_HIGH) begin
                            n_tr       = {1'b0, v[4:3], r_tr[4:0]};
                            n_last_cmd = lsid_pkg::CMD_MT_HIGH;
                            n_e0       = mk_res(lsid_pkg::CODE_MT_HIGH, '0, 1'b1);
                        end else if ((v & lsid_pkg::CMD_CLASS_MASK) == lsid_pkg::CMD_MT_LOW) begin
                            n_tr       = {r_tr[7:5], v[4:0]};
                            n_last_cmd = lsid_pkg::CMD_MT_LOW;
                            n_e0       = mk_res(lsid_pkg::CODE_MT_LOW, '0, 1'b1);
                        end else begin
                            if (v >= lsid_pkg::MODE_FIRST && v <= lsid_pkg::MODE_LAST) begin
                                n_mode = v;
                            end
                            n_e0 = mk_res(cmd_code, '0, 1'b1);
                        end
                    end else if (kind == lsid_pkg::KIND_DATA_RD) begin
                        n_first = v;
                        n_bc    = 3'd1;
                        n_phase = lsid_pkg::PH_DATA;
                    end else if (kind == lsid_pkg::KIND_STOP || kind == lsid_pkg::KIND_RSTART) begin
                        n_e0    = mk_res(lsid_pkg::CODE_CHECK, '0, 1'b1);
                        n_cnt   = 2'd1;
                        n_phase = (kind == lsid_pkg::KIND_RSTART) ? lsid_pkg::PH_ADDR
                                                                   : lsid_pkg::PH_IDLE;
                    end
                end
                default: begin
                    if (kind == lsid_pkg::KIND_DATA_WR || kind == lsid_pkg::KIND_DATA_RD) begin
                        if (!r_wd && r_bc < lsid_pkg::BYTE_MAX) begin
                            if (r_bc == 3'd0) begin
                                n_first = v;
                            end else if (r_bc == 3'd1) begin
                                n_second = v;
                            end
                            n_bc = r_bc + 3'd1;
                        end
                    end else if (kind == lsid_pkg::KIND_RSTART) begin
                        do_finish = 1'b1;
                        n_phase   = lsid_pkg::PH_ADDR;
                    end else if (kind == lsid_pkg::KIND_STOP) begin
                        do_finish = 1'b1;
                        n_phase   = lsid_pkg::PH_IDLE;
                    end
                end
            endcase

            if (do_finish) begin
                n_bc = '0;
                if (r_wd) begin
                    n_raw = 16'd1;
                    if (has_mt && has_mode) begin
                        n_e0    = mk_res(lsid_pkg::CODE_MTREG, 16'(r_tr), 1'b0);
                        n_e1    = mk_res(lsid_pkg::CODE_SENS, '0, 1'b1);
                        n_cnt   = 2'd2;
                        n_sc_hi = 1'b1;
                        n_state = lsid_pkg::ST_PREP;
                    end else if (has_mt) begin
                        n_e0  = mk_res(lsid_pkg::CODE_MTREG, 16'(r_tr), 1'b1);
                        n_cnt = 2'd1;
                    end else if (has_mode) begin
                        n_e0    = mk_res(lsid_pkg::CODE_SENS, '0, 1'b1);
                        n_cnt   = 2'd1;
                        n_sc_hi = 1'b0;
                        n_state = lsid_pkg::ST_PREP;
                    end
                end else if (r_bc >= lsid_pkg::BYTE_PAIR) begin
                    n_raw   = {r_second, r_first};
                    n_e0    = mk_res(lsid_pkg::CODE_DATA, {r_second, r_first}, 1'b0);
                    n_e1    = mk_res(lsid_pkg::CODE_LIGHT, {r_second, r_first}, 1'b1);
                    n_cnt   = 2'd2;
                    n_sc_hi = 1'b1;
                    n_state = lsid_pkg::ST_PREP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lsid_pkg::PH_IDLE;
            r_state     <= lsid_pkg::ST_IDLE;
            r_slave     <= lsid_pkg::SLAVE_RESET;
            r_wd        <= 1'b0;
            r_last_cmd  <= '0;
            r_mode      <= lsid_pkg::MODE_RESET;
            r_tr        <= lsid_pkg::MTREG_RESET;
            r_first     <= '0;
            r_second    <= '0;
            r_bc        <= '0;
            r_cnt       <= '0;
            r_sc_hi     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_state     <= n_state;
            r_slave     <= n_slave;
            r_wd        <= n_wd;
            r_last_cmd  <= n_last_cmd;
            r_mode      <= n_mode;
            r_tr        <= n_tr;
            r_first     <= n_first;
            r_second    <= n_second;
            r_bc        <= n_bc;
            r_cnt       <= n_cnt;
            r_sc_hi     <= n_sc_hi;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_acc <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0   <= n_e0;
        r_e1   <= n_e1;
        r_raw  <= n_raw;
        r_out  <= n_out;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_step <= n_step;
    end

    // checks
    `ASSERT_IMPL(a_div_has_job, i_clk, i_rst_n, r_state != lsid_pkg::ST_IDLE, r_cnt != 2'd0, "scaling without pending results")
    `ASSERT_NEXT(a_fin_to_idle, i_clk, i_rst_n, r_state == lsid_pkg::ST_FIN, r_state == lsid_pkg::ST_IDLE, "divider did not retire")
    `ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, r_state == lsid_pkg::ST_DIV, r_rem < r_den, "divider remainder out of range")
    `ASSERT_ALWAYS(a_byte_cnt, i_clk, i_rst_n, r_bc <= lsid_pkg::BYTE_MAX, "read byte count overflow")

endmodule
